FILE: src/sdsc_pkg.sv
// ============================================================================
// Sparse-to-dense scatter checker: shared definitions
// Widths, status codes, register indexes and the types passed between the
// configuration block, the coordinate lanes and the merge logic.
// ============================================================================
package sdsc_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int ADDR_BITS   = 48;
    localparam int COORD_SLOTS = 4;
    localparam int DIM_CAP     = (MAX_DIMS < COORD_SLOTS) ? MAX_DIMS : COORD_SLOTS;

    localparam int COORD_W     = 14;
    localparam int SHAPE_W     = 13;
    localparam int VALUE_W     = 64;
    localparam int WADDR_W     = 48;
    localparam int STATUS_W    = 3;
    localparam int NDIM_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int SLOT_IDX_W  = (COORD_SLOTS > 1) ? $clog2(COORD_SLOTS) : 1;

    // Stride multiplies are split into two half-width partial products.
    localparam int STRIDE_LO_W = ADDR_BITS / 2;
    localparam int STRIDE_HI_W = ADDR_BITS - STRIDE_LO_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_OUT_OF_BOUNDS = 3'd1,
        ST_OUT_OF_ORDER  = 3'd2,
        ST_REPEATED      = 3'd3,
        ST_SUPPRESSED    = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_DIM0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_DIM1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_DIM2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_DIM3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALIDATE   = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SHAPE_W-1:0]        shape_t;
    typedef logic [ADDR_BITS-1:0]      stride_t;

    typedef logic [COORD_SLOTS-1:0][COORD_W-1:0]   coord_vec_t;
    typedef logic [COORD_SLOTS-1:0][SHAPE_W-1:0]   shape_vec_t;
    typedef logic [COORD_SLOTS-1:0][ADDR_BITS-1:0] stride_vec_t;

    typedef struct packed {
        logic in_bounds;
        logic greater;
        logic less;
    } lane_flags_t;

    typedef lane_flags_t [COORD_SLOTS-1:0] lane_flags_vec_t;

    typedef struct packed {
        logic [NDIM_W-1:0] dims_used;
        logic              validate;
    } cfg_ctrl_t;

endpackage

FILE: src/sdsc_cfg.sv
// ============================================================================
// Configuration registers and stride rebuild
// Holds the shape registers and rebuilds the row-major stride table after a
// write, one dimension at a time (S_MUL, then S_ACC) on a shared split multiplier.
// ============================================================================
module sdsc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             busy,
    output sdsc_pkg::cfg_ctrl_t              ctrl,
    output sdsc_pkg::shape_vec_t             shapes,
    output sdsc_pkg::stride_vec_t            strides
);
    import sdsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_MUL,
        S_ACC
    } rb_state_t;

    rb_state_t                        state_reg;
    logic [NDIM_W-1:0]                num_dims_reg;
    shape_vec_t                       shape_reg;
    logic                             validate_reg;
    stride_vec_t                      stride_reg;
    logic [SLOT_IDX_W-1:0]            idx_reg;
    logic [STRIDE_LO_W+SHAPE_W-1:0]   lo_reg;
    logic [STRIDE_HI_W+SHAPE_W-1:0]   hi_reg;

    logic [NDIM_W-1:0]                dims_used;
    logic [SLOT_IDX_W-1:0]            last_idx;
    logic [SLOT_IDX_W-1:0]            idx_dec;
    logic                             cfg_write;

    // Clamp the dimension count to 1..DIM_CAP.
    always_comb
    begin
        priority if (num_dims_reg == '0)
        begin
            dims_used = NDIM_W'(1);
        end
        else if (num_dims_reg > NDIM_W'(DIM_CAP))
        begin
            dims_used = NDIM_W'(DIM_CAP);
        end
        else
        begin
            dims_used = num_dims_reg;
        end
    end

    assign last_idx  = SLOT_IDX_W'(dims_used - NDIM_W'(1));
    assign idx_dec   = idx_reg - SLOT_IDX_W'(1);
    assign cfg_ready = (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            num_dims_reg <= NDIM_W'(1);
            validate_reg <= 1'b1;
            idx_reg      <= '0;
            for (int d = 0; d < COORD_SLOTS; d++)
            begin
                shape_reg[d]  <= SHAPE_W'(1);
                stride_reg[d] <= (d == 0) ? ADDR_BITS'(1) : '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_write)
                    begin
                        unique case (cfg_index)
                            CFG_NUM_DIMS:
                            begin
                                num_dims_reg <= cfg_data[NDIM_W-1:0];
                                state_reg    <= S_INIT;
                            end
                            CFG_SHAPE_DIM0:
                            begin
                                shape_reg[0] <= cfg_data[SHAPE_W-1:0];
                                state_reg    <= S_INIT;
                            end
                            CFG_SHAPE_DIM1:
                            begin
                                shape_reg[1] <= cfg_data[SHAPE_W-1:0];
                                state_reg    <= S_INIT;
                            end
                            CFG_SHAPE_DIM2:
                            begin
                                shape_reg[2] <= cfg_data[SHAPE_W-1:0];
                                state_reg    <= S_INIT;
                            end
                            CFG_SHAPE_DIM3:
                            begin
                                shape_reg[3] <= cfg_data[SHAPE_W-1:0];
                                state_reg    <= S_INIT;
                            end
                            CFG_VALIDATE:
                            begin
                                validate_reg <= cfg_data[0];
                                state_reg    <= S_INIT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INIT:
                begin
                    // Innermost dimension in use has unit stride; unused slots hold zero.
                    for (int d = 0; d < COORD_SLOTS; d++)
                    begin
                        stride_reg[d] <= (SLOT_IDX_W'(d) == last_idx) ? ADDR_BITS'(1) : '0;
                    end
                    idx_reg              <= last_idx;
                    state_reg            <= (last_idx == '0) ? S_IDLE : S_MUL;
                end
                S_MUL:
                begin
                    lo_reg    <= stride_reg[idx_reg][STRIDE_LO_W-1:0] * shape_reg[idx_reg];
                    hi_reg    <= stride_reg[idx_reg][ADDR_BITS-1:STRIDE_LO_W]
                                 * shape_reg[idx_reg];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    stride_reg[idx_dec] <= ADDR_BITS'(lo_reg)
                                           + ADDR_BITS'({hi_reg, {STRIDE_LO_W{1'b0}}});
                    idx_reg             <= idx_dec;
                    state_reg           <= (idx_reg == SLOT_IDX_W'(1)) ? S_IDLE : S_MUL;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ctrl.dims_used = dims_used;
    assign ctrl.validate  = validate_reg;
    assign shapes         = shape_reg;
    assign strides        = stride_reg;

endmodule

FILE: src/sdsc_lane.sv
// ============================================================================
// Coordinate lane
// Checks one coordinate against its dimension size and the previous entry,
// and registers its stride contribution to the linear address.
// ============================================================================
module sdsc_lane (
    input  logic                  clk,
    input  logic                  load,
    input  sdsc_pkg::coord_t      coord,
    input  sdsc_pkg::coord_t      prev,
    input  sdsc_pkg::shape_t      shape,
    input  sdsc_pkg::stride_t     stride,
    output sdsc_pkg::lane_flags_t flags,
    output sdsc_pkg::stride_t     product
);
    import sdsc_pkg::*;

    logic [SHAPE_W-1:0]             magnitude;
    logic [STRIDE_LO_W+SHAPE_W-1:0] lo_prod;
    logic [STRIDE_HI_W+SHAPE_W-1:0] hi_prod;
    stride_t                        product_next;
    stride_t                        product_reg;

    assign magnitude = coord[SHAPE_W-1:0];

    assign flags.in_bounds = !coord[COORD_W-1] && (magnitude < shape);
    assign flags.greater   = coord > prev;
    assign flags.less      = coord < prev;

    assign lo_prod      = stride[STRIDE_LO_W-1:0] * magnitude;
    assign hi_prod      = stride[ADDR_BITS-1:STRIDE_LO_W] * magnitude;
    assign product_next = ADDR_BITS'(lo_prod) + ADDR_BITS'({hi_prod, {STRIDE_LO_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

FILE: src/sdsc_merge.sv
// ============================================================================
// Lane merge
// Combines lane flags into one status (suppression, then bounds, then order, then repeat) and
// sums the registered lane products into the linear address.
// ============================================================================
module sdsc_merge (
    input  sdsc_pkg::cfg_ctrl_t       ctrl,
    input  sdsc_pkg::lane_flags_vec_t flags,
    input  logic                      have_prev,
    input  logic                      sticky,
    input  sdsc_pkg::stride_vec_t     products,
    output sdsc_pkg::status_t         check_status,
    output sdsc_pkg::stride_t         address
);
    import sdsc_pkg::*;

    logic    in_bounds;
    logic    different;
    logic    increasing;
    logic    order_on;
    stride_t sum;

    // First differing dimension decides the lexicographic order.
    always_comb
    begin
        in_bounds  = 1'b1;
        different  = 1'b0;
        increasing = 1'b1;
        for (int d = 0; d < COORD_SLOTS; d++)
        begin
            if (NDIM_W'(d) < ctrl.dims_used)
            begin
                if (!flags[d].in_bounds)
                begin
                    in_bounds = 1'b0;
                end
                if (!different && flags[d].less)
                begin
                    increasing = 1'b0;
                end
                if (flags[d].greater)
                begin
                    different = 1'b1;
                end
            end
        end
    end

    assign order_on = ctrl.validate && have_prev;

    always_comb
    begin
        priority if (sticky)
        begin
            check_status = ST_SUPPRESSED;
        end
        else if (!in_bounds)
        begin
            check_status = ST_OUT_OF_BOUNDS;
        end
        else if (order_on && !increasing)
        begin
            check_status = ST_OUT_OF_ORDER;
        end
        else if (order_on && !different)
        begin
            check_status = ST_REPEATED;
        end
        else
        begin
            check_status = ST_OK;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int d = 0; d < COORD_SLOTS; d++)
        begin
            if (NDIM_W'(d) < ctrl.dims_used)
            begin
                sum = sum + products[d];
            end
        end
    end

    assign address = sum;

endmodule

FILE: src/sparse_to_dense_scatter_checker.sv
// ============================================================================
// Sparse-to-dense scatter checker
// Validates sparse entries and turns valid ones into dense-store writes.
// ============================================================================
// Each input request carries one sparse entry (up to four signed coordinates
// and a 64-bit value) and produces exactly one result. The block takes one
// request per clock cycle while in_ready is high: each coordinate runs in its
// own lane (bounds check, compare against the previous entry, stride multiply),
// and a merge stage turns the lane flags into a status in the accept cycle and
// sums the lane products one stage later. A result passes through stage A into
// the output register and sits there, so a new request is accepted while a
// finished result still waits on out_ready. Status is 0 ok, 1 out of bounds,
// 2 out of order, 3 repeated, 4 suppressed; the first error in a set is sticky
// until a request with first_entry set, and a consumer must discard the dense
// store after any error. On an error, write_enable, write_address and write_data
// are zero. After each configuration write the stride table is rebuilt on one
// shared split multiplier: an init step, then a multiply and an accumulate step
// per dimension beyond the first; during that time in_ready and cfg_ready are
// low. in_ready is also held low while cfg_valid is high, so a register write
// always takes effect before the next entry.
// ============================================================================
module sparse_to_dense_scatter_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sdsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sdsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    // entry request channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   first_entry,
    input  logic signed [sdsc_pkg::COORD_W-1:0]    coord0,
    input  logic signed [sdsc_pkg::COORD_W-1:0]    coord1,
    input  logic signed [sdsc_pkg::COORD_W-1:0]    coord2,
    input  logic signed [sdsc_pkg::COORD_W-1:0]    coord3,
    input  logic [sdsc_pkg::VALUE_W-1:0]           entry_value,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   write_enable,
    output logic [sdsc_pkg::WADDR_W-1:0]           write_address,
    output logic [sdsc_pkg::VALUE_W-1:0]           write_data,
    output logic [sdsc_pkg::STATUS_W-1:0]          status
);
    import sdsc_pkg::*;

    // configuration
    logic            cfg_busy;
    cfg_ctrl_t       cfg_ctrl;
    shape_vec_t      shapes;
    stride_vec_t     strides;

    // set state
    coord_vec_t      prev_reg;
    logic            have_reg;
    logic            sticky_reg;

    // accept stage
    coord_vec_t      coords;
    logic            accept;
    logic            eff_have;
    logic            eff_sticky;
    lane_flags_vec_t lane_flags;
    stride_vec_t     lane_products;
    status_t         check_status;
    logic            check_ok;
    stride_t         merged_address;

    // stage A: lane products registered
    logic            a_valid_reg;
    logic            a_ok_reg;
    status_t         a_status_reg;
    logic [VALUE_W-1:0] a_data_reg;

    // stage B: output register
    logic            out_valid_reg;
    logic            write_enable_reg;
    logic [WADDR_W-1:0] write_address_reg;
    logic [VALUE_W-1:0] write_data_reg;
    status_t         status_reg;

    logic            out_adv;
    logic            a_adv;

    sdsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (cfg_busy),
        .ctrl      (cfg_ctrl),
        .shapes    (shapes),
        .strides   (strides)
    );

    assign coords[0] = coord0;
    assign coords[1] = coord1;
    assign coords[2] = coord2;
    assign coords[3] = coord3;

    // Output register frees when empty or drained; stage A moves when B can take it.
    assign out_adv  = !out_valid_reg || out_ready;
    assign a_adv    = !a_valid_reg || out_adv;
    assign in_ready = a_adv && !cfg_busy && !cfg_valid;
    assign accept   = in_valid && in_ready;

    // A set start clears the history before this entry is checked.
    assign eff_have   = have_reg && !first_entry;
    assign eff_sticky = sticky_reg && !first_entry;

    for (genvar g = 0; g < COORD_SLOTS; g++)
    begin : g_lane
        sdsc_lane u_lane (
            .clk     (clk),
            .load    (accept),
            .coord   (coords[g]),
            .prev    (prev_reg[g]),
            .shape   (shapes[g]),
            .stride  (strides[g]),
            .flags   (lane_flags[g]),
            .product (lane_products[g])
        );
    end

    sdsc_merge u_merge (
        .ctrl         (cfg_ctrl),
        .flags        (lane_flags),
        .have_prev    (eff_have),
        .sticky       (eff_sticky),
        .products     (lane_products),
        .check_status (check_status),
        .address      (merged_address)
    );

    assign check_ok = (check_status == ST_OK);

    // Advance set history: a good entry becomes the new previous entry, any
    // error (or suppression) keeps the history and holds the sticky error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            have_reg   <= 1'b0;
            sticky_reg <= 1'b0;
        end
        else if (accept)
        begin
            sticky_reg <= !check_ok;
            have_reg   <= check_ok || eff_have;
            if (check_ok)
            begin
                for (int d = 0; d < COORD_SLOTS; d++)
                begin
                    prev_reg[d] <= (NDIM_W'(d) < cfg_ctrl.dims_used) ? coords[d] : '0;
                end
            end
        end
    end

    // Stage A control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= accept;
        end
    end

    // Stage A payload: hold status and value next to the lane products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ok_reg     <= check_ok;
            a_status_reg <= check_status;
            a_data_reg   <= entry_value;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    // Output register payload: drop address and data on any error
    always_ff @(posedge clk)
    begin
        if (out_adv && a_valid_reg)
        begin
            write_enable_reg  <= a_ok_reg;
            write_address_reg <= a_ok_reg ? WADDR_W'(merged_address) : '0;
            write_data_reg    <= a_ok_reg ? a_data_reg : '0;
            status_reg        <= a_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = write_enable_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign status        = status_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |-> (status == ST_OK))
        else $error("write issued with a non-ok status");

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (write_address == '0 && write_data == '0))
        else $error("address or data not zeroed on an error result");

    a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_busy |-> !in_ready)
        else $error("entry accepted while strides are rebuilt");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !check_ok) |=> sticky_reg)
        else $error("sticky error not held after an error entry");

    a_ok_records: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && check_ok) |=> (have_reg && !sticky_reg))
        else $error("good entry not recorded as previous entry");

endmodule
